### rtl/ordered_linear_probe_hash_table_unit_macros.svh
// Assertion macros used by the checker file of the hash table unit.
`ifndef ORDERED_LINEAR_PROBE_HASH_TABLE_UNIT_MACROS_SVH
`define ORDERED_LINEAR_PROBE_HASH_TABLE_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OLPH_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hash table unit check failed");

// The consequent must hold in the cycle after the antecedent.
`define OLPH_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hash table unit check failed");

`endif

### rtl/olph_pkg.sv
// Shared types and constants of the ordered hash table unit.
`default_nettype none
package olph_pkg;
	localparam int DEF_CAPACITY   = 1024;
	localparam int DEF_VALUE_BITS = 32;
	localparam int KEY_BITS       = 32;
	localparam int CFG_BITS       = 11;
	localparam int CNT_BITS       = 11;
	localparam int PROBE_BITS     = 10;
	localparam logic [CFG_BITS-1:0] CFG_RESET = 11'd1024;

	localparam logic [1:0] MARK_EMPTY = 2'd0;
	localparam logic [1:0] MARK_FULL  = 2'd1;
	localparam logic [1:0] MARK_TOMB  = 2'd2;

	localparam logic [1:0] KIND_INSERT = 2'd0;
	localparam logic [1:0] KIND_QUERY  = 2'd1;
	localparam logic [1:0] KIND_REMOVE = 2'd2;
	localparam logic [1:0] KIND_NONE   = 2'd3;

	localparam logic [1:0] STAT_SUCCESS   = 2'd0;
	localparam logic [1:0] STAT_DUPLICATE = 2'd1;
	localparam logic [1:0] STAT_FULL      = 2'd2;
	localparam logic [1:0] STAT_NOT_FOUND = 2'd3;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HOME,
		ST_START,
		ST_RD,
		ST_CK1,
		ST_CK2,
		ST_END,
		ST_SC_STEP,
		ST_SC_CK,
		ST_SH_RD,
		ST_SH_WR,
		ST_WR,
		ST_DONE
	} state_t;
endpackage
`default_nettype wire

### rtl/ordered_linear_probe_hash_table_unit.sv
// Ordered hash table unit: the top level with its sequencer and the slot store.
// Records live in one slot RAM (mark, key and value per row) in the order of
// their home slot, home = (key * bucket_count) >> 32. After reset the unit
// clears every row of the slot RAM and accepts no item while it does so;
// configuration writes are taken always. One item is worked at a time.
// A rejected insert or an unused kind goes straight to the result state: its
// result is registered once the output register is free, and the next item
// can be accepted after that. Otherwise the home multiply comes first, and
// each slot read by the probe goes through a RAM read, a home multiply of the
// stored key and a decision; a probe of length P reads P + 1 slots, since the
// first slot read is not counted in P. A remove that hits, or an insert into
// an empty slot, ends with a write of that slot. An insert that lands in an
// occupied slot then scans forward slot by slot to the first slot that is not
// full and moves each slot of that run right, a read and then a write per
// slot, all through the one slot RAM, before its final write.
// A result waits in an output register, so the next item is accepted while
// the last result still waits for its transfer.
`default_nettype none
module ordered_linear_probe_hash_table_unit #(
	parameter int CAPACITY   = olph_pkg::DEF_CAPACITY,
	parameter int VALUE_BITS = olph_pkg::DEF_VALUE_BITS
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic [olph_pkg::CFG_BITS-1:0]        bucket_count,
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire logic [1:0]                           kind,
	input  wire logic [olph_pkg::KEY_BITS-1:0]        key,
	input  wire logic [31:0]                          value,
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output logic      [1:0]                           status,
	output logic      [31:0]                          found_value,
	output logic      [olph_pkg::PROBE_BITS-1:0]      probe_length
);
	localparam int IW = $clog2(CAPACITY);
	localparam int BW = IW + 1;
	localparam int KB = olph_pkg::KEY_BITS;
	localparam int RW = 2 + KB + VALUE_BITS;
	localparam int CB = olph_pkg::CNT_BITS;

	olph_pkg::state_t state_q, state_d;

	logic [olph_pkg::CFG_BITS-1:0] cfg_q;
	logic [CB-1:0]         rec_q, tomb_q;
	logic [IW-1:0]         head_q;
	logic [1:0]            kind_q;
	logic [KB-1:0]         key_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [BW-1:0]         b_q;
	logic [IW-1:0]         h_q, s_q, e_q, p_q, clr_q;
	logic [BW-1:0]         n_q, m_q;
	logic                  wrapped_q, last_q, hit_q;
	logic [RW-1:0]         row_q;
	logic [1:0]            res_status_q;
	logic [VALUE_BITS-1:0] res_found_q;

	logic                  out_valid_q;
	logic [1:0]            status_q;
	logic [31:0]           found_q;
	logic [olph_pkg::PROBE_BITS-1:0] probe_q;

	// RAM and multiplier hookup.
	logic                  ram_we;
	logic [IW-1:0]         ram_waddr, ram_raddr;
	logic [RW-1:0]         ram_wdata, ram_rdata;
	logic [KB-1:0]         hash_key;
	logic [BW-1:0]         hash_home;

	// Bucket count in use, clamped to one to CAPACITY.
	logic [31:0]           cfg_ext, bu_ext;
	logic [BW-1:0]         b_new;
	logic [IW-1:0]         head_fix;
	logic                  accept, load_out;

	// Fields of the latched and the freshly read row.
	logic [1:0]            row_mark, rd_mark;
	logic [KB-1:0]         row_key;
	logic [VALUE_BITS-1:0] row_val;
	logic                  row_hit, row_stop;

	function automatic logic [IW-1:0] inc_idx(input logic [IW-1:0] x, input logic [BW-1:0] b);
		logic [BW-1:0] nx;
		nx = BW'(x) + BW'(1);
		return (nx == b) ? '0 : nx[IW-1:0];
	endfunction

	function automatic logic [IW-1:0] dec_idx(input logic [IW-1:0] x, input logic [BW-1:0] b);
		logic [BW-1:0] bm;
		bm = b - BW'(1);
		return (x == '0) ? bm[IW-1:0] : x - IW'(1);
	endfunction

	assign cfg_ext = 32'(cfg_q);
	assign bu_ext  = (cfg_ext == 32'd0) ? 32'd1 :
			 (cfg_ext > 32'(CAPACITY)) ? 32'(CAPACITY) : cfg_ext;
	assign b_new    = bu_ext[BW-1:0];
	assign head_fix = (BW'(head_q) >= b_new) ? '0 : head_q;

	assign accept   = in_valid && in_ready;
	assign load_out = (state_q == olph_pkg::ST_DONE) && (!out_valid_q || out_ready);

	assign row_mark = row_q[RW-1:RW-2];
	assign row_key  = row_q[RW-3:VALUE_BITS];
	assign row_val  = row_q[VALUE_BITS-1:0];
	assign rd_mark  = ram_rdata[RW-1:RW-2];
	assign row_hit  = (row_mark == olph_pkg::MARK_FULL) && (row_key == key_q);
	assign row_stop = (row_mark == olph_pkg::MARK_EMPTY) ||
			  ((row_mark == olph_pkg::MARK_FULL) && (hash_home > BW'(h_q)));

	assign cfg_ready   = 1'b1;
	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign found_value = found_q;
	assign probe_length = probe_q;

	olph_ram #(
		.WIDTH(RW),
		.DEPTH(CAPACITY)
	) u_slots (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	olph_hash #(
		.BW(BW)
	) u_hash (
		.clk     (clk),
		.key     (hash_key),
		.buckets (b_q),
		.home    (hash_home)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			olph_pkg::ST_CLEAR: begin
				if (clr_q == IW'(CAPACITY - 1)) state_d = olph_pkg::ST_IDLE;
			end
			olph_pkg::ST_IDLE: begin
				if (accept) begin
					if (kind == olph_pkg::KIND_NONE) begin
						state_d = olph_pkg::ST_DONE;
					end else if (kind == olph_pkg::KIND_INSERT &&
						     32'(rec_q) >= bu_ext) begin
						state_d = olph_pkg::ST_DONE;
					end else begin
						state_d = olph_pkg::ST_HOME;
					end
				end
			end
			olph_pkg::ST_HOME:  state_d = olph_pkg::ST_START;
			olph_pkg::ST_START: state_d = olph_pkg::ST_RD;
			olph_pkg::ST_RD:    state_d = olph_pkg::ST_CK1;
			olph_pkg::ST_CK1:   state_d = olph_pkg::ST_CK2;
			olph_pkg::ST_CK2: begin
				if (last_q || row_hit || row_stop) state_d = olph_pkg::ST_END;
				else state_d = olph_pkg::ST_RD;
			end
			olph_pkg::ST_END: begin
				case (kind_q)
					olph_pkg::KIND_INSERT: begin
						if (hit_q) state_d = olph_pkg::ST_DONE;
						else if (row_mark != olph_pkg::MARK_EMPTY)
							state_d = olph_pkg::ST_SC_STEP;
						else state_d = olph_pkg::ST_WR;
					end
					olph_pkg::KIND_REMOVE: begin
						state_d = hit_q ? olph_pkg::ST_WR : olph_pkg::ST_DONE;
					end
					default: state_d = olph_pkg::ST_DONE;
				endcase
			end
			olph_pkg::ST_SC_STEP: state_d = olph_pkg::ST_SC_CK;
			olph_pkg::ST_SC_CK: begin
				if (rd_mark == olph_pkg::MARK_FULL && m_q < b_q)
					state_d = olph_pkg::ST_SC_STEP;
				else state_d = olph_pkg::ST_SH_RD;
			end
			olph_pkg::ST_SH_RD: begin
				state_d = (p_q == s_q) ? olph_pkg::ST_WR : olph_pkg::ST_SH_WR;
			end
			olph_pkg::ST_SH_WR: state_d = olph_pkg::ST_SH_RD;
			olph_pkg::ST_WR:    state_d = olph_pkg::ST_DONE;
			olph_pkg::ST_DONE: begin
				if (load_out) state_d = olph_pkg::ST_IDLE;
			end
			default: state_d = olph_pkg::ST_IDLE;
		endcase
	end

	// Outputs of the sequencer: RAM port, multiplier operand and input ready.
	always_comb begin
		in_ready  = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = s_q;
		ram_wdata = ram_rdata;
		ram_raddr = s_q;
		hash_key  = key_q;
		case (state_q)
			olph_pkg::ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
			end
			olph_pkg::ST_IDLE:    in_ready = 1'b1;
			olph_pkg::ST_CK1:     hash_key = ram_rdata[RW-3:VALUE_BITS];
			olph_pkg::ST_SC_STEP: ram_raddr = inc_idx(e_q, b_q);
			olph_pkg::ST_SH_RD:   ram_raddr = dec_idx(p_q, b_q);
			olph_pkg::ST_SH_WR: begin
				ram_we    = 1'b1;
				ram_waddr = p_q;
				ram_wdata = ram_rdata;
			end
			olph_pkg::ST_WR: begin
				ram_we    = 1'b1;
				ram_waddr = s_q;
				if (kind_q == olph_pkg::KIND_INSERT)
					ram_wdata = {olph_pkg::MARK_FULL, key_q, val_q};
				else
					ram_wdata = {olph_pkg::MARK_TOMB, row_key, row_val};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= olph_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Control state: configuration, counts, head, clear sweep, output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q       <= olph_pkg::CFG_RESET;
			rec_q       <= '0;
			tomb_q      <= '0;
			head_q      <= '0;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) cfg_q <= bucket_count;
			if (state_q == olph_pkg::ST_CLEAR) clr_q <= clr_q + IW'(1);
			if (accept) head_q <= head_fix;
			if (state_q == olph_pkg::ST_END) begin
				if (kind_q == olph_pkg::KIND_INSERT && !hit_q &&
				    row_mark == olph_pkg::MARK_EMPTY && wrapped_q && s_q == head_q)
					head_q <= inc_idx(head_q, b_q);
				if (kind_q == olph_pkg::KIND_REMOVE && hit_q) begin
					if (tomb_q != {CB{1'b1}}) tomb_q <= tomb_q + CB'(1);
					if (rec_q != '0) rec_q <= rec_q - CB'(1);
				end
			end
			// End of the scan: a tombstone there is used up, and a run
			// that wraps past the head moves the head on.
			if (state_q == olph_pkg::ST_SC_CK &&
			    !(rd_mark == olph_pkg::MARK_FULL && m_q < b_q)) begin
				if (rd_mark == olph_pkg::MARK_TOMB && tomb_q != '0)
					tomb_q <= tomb_q - CB'(1);
				if ((e_q < s_q || wrapped_q) && e_q >= head_q)
					head_q <= inc_idx(head_q, b_q);
			end
			if (state_q == olph_pkg::ST_WR && kind_q == olph_pkg::KIND_INSERT)
				rec_q <= rec_q + CB'(1);
			if (load_out) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// Item datapath.
	always_ff @(posedge clk) begin
		case (state_q)
			olph_pkg::ST_IDLE: begin
				if (accept) begin
					kind_q       <= kind;
					key_q        <= key;
					val_q        <= VALUE_BITS'(value);
					b_q          <= b_new;
					n_q          <= '0;
					hit_q        <= 1'b0;
					res_found_q  <= '0;
					res_status_q <= (kind == olph_pkg::KIND_INSERT &&
							 32'(rec_q) >= bu_ext) ?
							olph_pkg::STAT_FULL : olph_pkg::STAT_NOT_FOUND;
				end
			end
			olph_pkg::ST_START: begin
				h_q       <= hash_home[IW-1:0];
				s_q       <= (hash_home[IW-1:0] > head_q) ? hash_home[IW-1:0] : head_q;
				wrapped_q <= 1'b0;
				last_q    <= 1'b0;
			end
			olph_pkg::ST_CK1: row_q <= ram_rdata;
			olph_pkg::ST_CK2: begin
				if (!last_q && row_hit) begin
					hit_q <= 1'b1;
				end else if (!last_q && !row_stop) begin
					s_q <= inc_idx(s_q, b_q);
					n_q <= n_q + BW'(1);
					if (BW'(s_q) + BW'(1) == b_q) wrapped_q <= 1'b1;
					if (inc_idx(s_q, b_q) == head_q) last_q <= 1'b1;
				end
			end
			olph_pkg::ST_END: begin
				e_q <= s_q;
				m_q <= '0;
				case (kind_q)
					olph_pkg::KIND_INSERT: begin
						res_status_q <= hit_q ? olph_pkg::STAT_DUPLICATE :
								olph_pkg::STAT_SUCCESS;
					end
					olph_pkg::KIND_QUERY: begin
						if (hit_q) begin
							res_status_q <= olph_pkg::STAT_SUCCESS;
							res_found_q  <= row_val;
						end
					end
					olph_pkg::KIND_REMOVE: begin
						if (hit_q) res_status_q <= olph_pkg::STAT_SUCCESS;
					end
					default: begin
					end
				endcase
			end
			olph_pkg::ST_SC_STEP: begin
				e_q <= inc_idx(e_q, b_q);
				m_q <= m_q + BW'(1);
			end
			olph_pkg::ST_SC_CK: p_q <= e_q;
			olph_pkg::ST_SH_WR: p_q <= dec_idx(p_q, b_q);
			default: begin
			end
		endcase
		if (load_out) begin
			status_q <= res_status_q;
			found_q  <= 32'(res_found_q);
			probe_q  <= (32'(n_q) > 32'd1023) ? 10'd1023 : 10'(n_q);
		end
	end
endmodule
`default_nettype wire

### rtl/olph_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module olph_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

### rtl/olph_hash.sv
// Registered home-slot multiplier: home = (key * buckets) >> 32.
`default_nettype none
module olph_hash #(
	parameter int BW = 11
) (
	input  wire logic                           clk,
	input  wire logic [olph_pkg::KEY_BITS-1:0]  key,
	input  wire logic [BW-1:0]                  buckets,
	output logic      [BW-1:0]                  home
);
	localparam int PW = olph_pkg::KEY_BITS + BW;
	logic [PW-1:0] prod;

	assign prod = PW'(key) * PW'(buckets);

	always_ff @(posedge clk) begin
		home <= prod[PW-1:olph_pkg::KEY_BITS];
	end
endmodule
`default_nettype wire

### rtl/olph_checker.sv
// Port-level checker of the ordered hash table unit and its bind.
`default_nettype none
`include "ordered_linear_probe_hash_table_unit_macros.svh"
module olph_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [1:0]  status,
	input wire logic [31:0] found_value,
	input wire logic [9:0]  probe_length
);
	`OLPH_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status))
	`OLPH_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready)
	`OLPH_ASSERT_SAME(a_full_no_probe, out_valid && status == olph_pkg::STAT_FULL, probe_length == 10'd0)
	`OLPH_ASSERT_SAME(a_value_only_ok, out_valid && status != olph_pkg::STAT_SUCCESS, found_value == 32'd0)
endmodule

bind ordered_linear_probe_hash_table_unit olph_checker u_olph_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.status       (status),
	.found_value  (found_value),
	.probe_length (probe_length)
);
`default_nettype wire
